### rtl/scancode_to_ascii_decoder_assert.svh
// scancode_to_ascii_decoder_assert.svh: assertion macros for the decoder checker
// depends on signals clk and rst_n in the scope where a macro is used
`ifndef SCANCODE_TO_ASCII_DECODER_ASSERT_SVH
`define SCANCODE_TO_ASCII_DECODER_ASSERT_SVH

// same-cycle implication, off while in reset
`define S2A_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define S2A_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/s2a_pkg.sv
// s2a_pkg: key codes and scan-code set 1 lookup tables for the decoder
// no dependencies
`default_nettype none

package s2a_pkg;

    typedef logic [7:0] code_t;
    typedef logic [6:0] index_t;

    // internal key codes held in the tables
    localparam code_t K_CTRL_L  = 8'h81;
    localparam code_t K_CTRL_R  = 8'h82;
    localparam code_t K_SHIFT_L = 8'h83;
    localparam code_t K_SHIFT_R = 8'h84;
    localparam code_t K_ALT_L   = 8'h85;
    localparam code_t K_CAPS    = 8'h87;
    localparam code_t K_F1      = 8'h91;
    localparam code_t K_F11     = 8'h9b;
    localparam code_t K_F12     = 8'h9c;

    // raw byte codes
    localparam code_t SC_RELEASE_MIN = 8'h7f;
    localparam code_t SC_EXT_PREFIX  = 8'he0;

    // distance between upper and lower case letters
    localparam code_t CASE_OFFSET = 8'd32;

    // unshifted table
    function automatic code_t plain_code(input index_t idx);
        code_t code;
        code = 8'h00;
        case (idx)
            7'd1:  code = 8'h1b;  7'd2:  code = 8'h31;  7'd3:  code = 8'h32;  7'd4:  code = 8'h33;
            7'd5:  code = 8'h34;  7'd6:  code = 8'h35;  7'd7:  code = 8'h36;  7'd8:  code = 8'h37;
            7'd9:  code = 8'h38;  7'd10: code = 8'h39;  7'd11: code = 8'h30;  7'd12: code = 8'h2d;
            7'd13: code = 8'h3d;  7'd14: code = 8'h08;  7'd15: code = 8'h09;
            // q w e r t y u i
            7'd16: code = 8'h71;  7'd17: code = 8'h77;  7'd18: code = 8'h65;  7'd19: code = 8'h72;
            7'd20: code = 8'h74;  7'd21: code = 8'h79;  7'd22: code = 8'h75;  7'd23: code = 8'h69;
            // o p [ ] enter ctrl a s
            7'd24: code = 8'h6f;  7'd25: code = 8'h70;  7'd26: code = 8'h5b;  7'd27: code = 8'h5d;
            7'd28: code = 8'h0a;  7'd29: code = K_CTRL_L; 7'd30: code = 8'h61; 7'd31: code = 8'h73;
            // d f g h j k l ;
            7'd32: code = 8'h64;  7'd33: code = 8'h66;  7'd34: code = 8'h67;  7'd35: code = 8'h68;
            7'd36: code = 8'h6a;  7'd37: code = 8'h6b;  7'd38: code = 8'h6c;  7'd39: code = 8'h3b;
            // ' ` lshift \ z x c v
            7'd40: code = 8'h27;  7'd41: code = 8'h60;  7'd42: code = K_SHIFT_L; 7'd43: code = 8'h5c;
            7'd44: code = 8'h7a;  7'd45: code = 8'h78;  7'd46: code = 8'h63;  7'd47: code = 8'h76;
            // b n m , . / rshift *
            7'd48: code = 8'h62;  7'd49: code = 8'h6e;  7'd50: code = 8'h6d;  7'd51: code = 8'h2c;
            7'd52: code = 8'h2e;  7'd53: code = 8'h2f;  7'd54: code = K_SHIFT_R; 7'd55: code = 8'h2a;
            // alt space caps f1..f5
            7'd56: code = K_ALT_L; 7'd57: code = 8'h20; 7'd58: code = K_CAPS; 7'd59: code = 8'h91;
            7'd60: code = 8'h92;  7'd61: code = 8'h93;  7'd62: code = 8'h94;  7'd63: code = 8'h95;
            // f6..f10, keypad
            7'd64: code = 8'h96;  7'd65: code = 8'h97;  7'd66: code = 8'h98;  7'd67: code = 8'h99;
            7'd68: code = 8'h9a;  7'd71: code = 8'h37;
            7'd72: code = 8'h38;  7'd73: code = 8'h39;  7'd74: code = 8'h2d;  7'd75: code = 8'h34;
            7'd76: code = 8'h35;  7'd77: code = 8'h36;  7'd78: code = 8'h2b;  7'd79: code = 8'h31;
            7'd80: code = 8'h32;  7'd81: code = 8'h33;  7'd82: code = 8'h30;  7'd83: code = 8'h2e;
            7'd87: code = K_F11;  7'd88: code = K_F12;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    // shifted table, identical to the plain one from the alt key upward
    function automatic code_t shift_code(input index_t idx);
        code_t code;
        code = 8'h00;
        case (idx)
            7'd1:  code = 8'h1b;  7'd2:  code = 8'h21;  7'd3:  code = 8'h40;  7'd4:  code = 8'h23;
            7'd5:  code = 8'h24;  7'd6:  code = 8'h25;  7'd7:  code = 8'h5e;  7'd8:  code = 8'h26;
            7'd9:  code = 8'h2a;  7'd10: code = 8'h28;  7'd11: code = 8'h29;  7'd12: code = 8'h5f;
            7'd13: code = 8'h2b;  7'd14: code = 8'h08;  7'd15: code = 8'h09;
            7'd16: code = 8'h51;  7'd17: code = 8'h57;  7'd18: code = 8'h45;  7'd19: code = 8'h52;
            7'd20: code = 8'h54;  7'd21: code = 8'h59;  7'd22: code = 8'h55;  7'd23: code = 8'h49;
            7'd24: code = 8'h4f;  7'd25: code = 8'h50;  7'd26: code = 8'h7b;  7'd27: code = 8'h7d;
            7'd28: code = 8'h0a;  7'd29: code = K_CTRL_L; 7'd30: code = 8'h41; 7'd31: code = 8'h53;
            7'd32: code = 8'h44;  7'd33: code = 8'h46;  7'd34: code = 8'h47;  7'd35: code = 8'h48;
            7'd36: code = 8'h4a;  7'd37: code = 8'h4b;  7'd38: code = 8'h4c;  7'd39: code = 8'h3a;
            7'd40: code = 8'h22;  7'd41: code = 8'h7e;  7'd42: code = K_SHIFT_L; 7'd43: code = 8'h7c;
            7'd44: code = 8'h5a;  7'd45: code = 8'h58;  7'd46: code = 8'h43;  7'd47: code = 8'h56;
            7'd48: code = 8'h42;  7'd49: code = 8'h4e;  7'd50: code = 8'h4d;  7'd51: code = 8'h3c;
            7'd52: code = 8'h3e;  7'd53: code = 8'h3f;  7'd54: code = K_SHIFT_R; 7'd55: code = 8'h2a;
            default: code = plain_code(idx);
        endcase
        return code;
    endfunction

    // control table, letters map to their ascii control codes
    function automatic code_t ctrl_code(input index_t idx);
        code_t code;
        code = 8'h00;
        case (idx)
            7'd16: code = 8'h11;  7'd17: code = 8'h17;  7'd18: code = 8'h05;  7'd19: code = 8'h12;
            7'd20: code = 8'h14;  7'd21: code = 8'h19;  7'd22: code = 8'h15;  7'd23: code = 8'h09;
            7'd24: code = 8'h0f;  7'd25: code = 8'h10;  7'd28: code = 8'h0d;  7'd30: code = 8'h01;
            7'd31: code = 8'h13;
            7'd32: code = 8'h04;  7'd33: code = 8'h06;  7'd34: code = 8'h07;  7'd35: code = 8'h08;
            7'd36: code = 8'h0a;  7'd37: code = 8'h0b;  7'd38: code = 8'h0c;
            7'd43: code = 8'h1c;  7'd44: code = 8'h1a;  7'd45: code = 8'h18;  7'd46: code = 8'h03;
            7'd47: code = 8'h16;
            7'd48: code = 8'h02;  7'd49: code = 8'h0e;  7'd50: code = 8'h0d;  7'd53: code = 8'h1f;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### rtl/scancode_to_ascii_decoder.sv
// Scan-code set 1 to ASCII decoder, top level; uses s2a_pkg for the key tables.
// Takes one keyboard byte per word on the scan channel and gives at most one
// character word on the char channel. A byte is first captured in an input
// register, then decoded against the shift, control, caps lock and
// extended-prefix flags, which are updated in that same cycle; a result is
// written to the output register and shows from there on char_valid. One byte
// is taken every clock unless scan_stall is high; the only feedback is the
// flag update in the decode stage. Presses of shift, control, caps lock, F1 to
// F11, releases, the 0xE0 prefix and the byte after it give no word. While a
// word waits in the output register, bytes that give no word keep flowing; a
// byte that gives a word waits in the input register and stalls the scan
// channel until the waiting word is taken.
`default_nettype none

module scancode_to_ascii_decoder #(
    parameter int TABLE_ENTRIES = 96
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       scan_valid,
    output logic            scan_stall,
    input  wire logic [7:0] scan_byte,
    output logic            char_valid,
    input  wire logic       char_stall,
    output logic [7:0]      char_code
);

    // table cutoff; entries at or beyond it read as zero
    localparam logic [7:0] TABLE_LIMIT = 8'(TABLE_ENTRIES);

    logic               in_valid_reg;
    s2a_pkg::code_t     in_byte_reg;
    logic               shift_l_reg, shift_l_next;
    logic               shift_r_reg, shift_r_next;
    logic               ctrl_l_reg, ctrl_l_next;
    logic               ctrl_r_reg, ctrl_r_next;
    logic               caps_reg, caps_next;
    logic               skip_reg, skip_next;
    logic               out_valid_reg;
    s2a_pkg::code_t     out_code_reg;

    s2a_pkg::index_t    idx;
    logic               in_range;
    logic               is_press;
    s2a_pkg::code_t     press_entry;
    s2a_pkg::code_t     release_entry;
    s2a_pkg::code_t     emit_code;
    logic               code_ok;
    logic               emit;
    logic               advance;
    logic               fire;

    // table lookups for the registered byte
    always_comb
    begin
        idx      = in_byte_reg[6:0];
        in_range = {1'b0, idx} < TABLE_LIMIT;
        is_press = in_byte_reg < s2a_pkg::SC_RELEASE_MIN;

        if (!in_range)
            press_entry = 8'h00;
        else if (ctrl_l_reg || ctrl_r_reg)
            press_entry = s2a_pkg::ctrl_code(idx);
        else if (shift_l_reg || shift_r_reg)
            press_entry = s2a_pkg::shift_code(idx);
        else
            press_entry = s2a_pkg::plain_code(idx);

        release_entry = in_range ? s2a_pkg::plain_code(idx) : 8'h00;
    end

    // decide whether a press yields a word, and apply caps lock
    always_comb
    begin
        code_ok = 1'b1;
        if (press_entry == 8'h00)
            code_ok = 1'b0;
        else if (press_entry inside {s2a_pkg::K_CTRL_L, s2a_pkg::K_CTRL_R,
                                     s2a_pkg::K_SHIFT_L, s2a_pkg::K_SHIFT_R,
                                     s2a_pkg::K_CAPS})
            code_ok = 1'b0;
        else if (press_entry inside {[s2a_pkg::K_F1 : s2a_pkg::K_F11]})
            code_ok = 1'b0;

        emit_code = press_entry;
        if (caps_reg)
        begin
            if (press_entry inside {[8'h61 : 8'h7a]})
                emit_code = press_entry - s2a_pkg::CASE_OFFSET;
            else if (press_entry inside {[8'h41 : 8'h5a]})
                emit_code = press_entry + s2a_pkg::CASE_OFFSET;
        end

        emit = in_valid_reg && !skip_reg && is_press && code_ok;
    end

    // the decode stage moves on unless its word would hit a full, stalled output
    assign advance    = !in_valid_reg || !out_valid_reg || !char_stall || !emit;
    assign fire       = in_valid_reg && advance;
    assign scan_stall = !advance;

    // flag updates for the byte being decoded
    always_comb
    begin
        shift_l_next = shift_l_reg;
        shift_r_next = shift_r_reg;
        ctrl_l_next  = ctrl_l_reg;
        ctrl_r_next  = ctrl_r_reg;
        caps_next    = caps_reg;
        skip_next    = skip_reg;
        if (skip_reg)
            skip_next = 1'b0;
        else if (is_press)
        begin
            case (press_entry)
                s2a_pkg::K_CTRL_L:  ctrl_l_next  = 1'b1;
                s2a_pkg::K_CTRL_R:  ctrl_r_next  = 1'b1;
                s2a_pkg::K_SHIFT_L: shift_l_next = 1'b1;
                s2a_pkg::K_SHIFT_R: shift_r_next = 1'b1;
                s2a_pkg::K_CAPS:    caps_next    = !caps_reg;
                default: ;
            endcase
        end
        else if (in_byte_reg == s2a_pkg::SC_EXT_PREFIX)
            skip_next = 1'b1;
        else
        begin
            case (release_entry)
                s2a_pkg::K_CTRL_L:  ctrl_l_next  = 1'b0;
                s2a_pkg::K_CTRL_R:  ctrl_r_next  = 1'b0;
                s2a_pkg::K_SHIFT_L: shift_l_next = 1'b0;
                s2a_pkg::K_SHIFT_R: shift_r_next = 1'b0;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (advance)
            in_valid_reg <= scan_valid;
    end

    always_ff @(posedge clk)
    begin
        if (scan_valid && advance)
            in_byte_reg <= scan_byte;
    end

    // modifier and prefix flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_l_reg <= 1'b0;
            shift_r_reg <= 1'b0;
            ctrl_l_reg  <= 1'b0;
            ctrl_r_reg  <= 1'b0;
            caps_reg    <= 1'b0;
            skip_reg    <= 1'b0;
        end
        else if (fire)
        begin
            shift_l_reg <= shift_l_next;
            shift_r_reg <= shift_r_next;
            ctrl_l_reg  <= ctrl_l_next;
            ctrl_r_reg  <= ctrl_r_next;
            caps_reg    <= caps_next;
            skip_reg    <= skip_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && emit)
            out_valid_reg <= 1'b1;
        else if (!char_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
            out_code_reg <= emit_code;
    end

    assign char_valid = out_valid_reg;
    assign char_code  = out_code_reg;

endmodule

`default_nettype wire

### rtl/s2a_checker.sv
// s2a_checker: port-level checks on the decoder, bound to its top level
// depends on scancode_to_ascii_decoder_assert.svh and the key codes in s2a_pkg
`default_nettype none

`include "scancode_to_ascii_decoder_assert.svh"

module s2a_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       scan_valid,
    input wire logic       scan_stall,
    input wire logic       char_valid,
    input wire logic       char_stall,
    input wire logic [7:0] char_code
);

    logic scan_take;
    logic char_wait;
    logic code_bad;

    // handshake terms used by the checks
    assign scan_take = scan_valid && !scan_stall;
    assign char_wait = char_valid && char_stall;

    // zero entries, shift and control codes, caps lock and F1 to F11 are never words
    assign code_bad = (char_code == 8'h00)
                   || (char_code inside {[s2a_pkg::K_CTRL_L : s2a_pkg::K_SHIFT_R],
                                         s2a_pkg::K_CAPS,
                                         [s2a_pkg::K_F1 : s2a_pkg::K_F11]});

    // a stalled word holds until taken
    `S2A_ASSERT_NEXT(a_char_hold, char_wait, char_valid && $stable(char_code), "word changed")

    // with an empty output the decoder never stalls its input
    `S2A_ASSERT_NOW(a_no_idle_stall, !char_valid, !scan_stall, "stall with output empty")

    // zero entries, shift and control codes, caps lock and F1 to F11 never reach the output
    `S2A_ASSERT_NOW(a_code_legal, char_valid, !code_bad, "illegal char code emitted")

    // an idle output fills only from a byte taken the cycle before
    `S2A_ASSERT_NEXT(a_latency, !char_valid && !$past(scan_take), !char_valid, "word too early")

endmodule

bind scancode_to_ascii_decoder s2a_checker u_s2a_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .scan_valid (scan_valid),
    .scan_stall (scan_stall),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code)
);

`default_nettype wire
